### rtl/core/efb_pkg.sv
// shared types, constants and helpers for the ethernet frame builder
`default_nettype none

package efb_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_SEED = 32'hFFFFFFFF;

	localparam logic [7:0] BYTE_START = 8'hFB;
	localparam logic [7:0] BYTE_PRE   = 8'h55;
	localparam logic [7:0] BYTE_SFD   = 8'hD5;

	// header bytes plus crc bytes
	localparam logic [15:0] FRAME_OVERHEAD = 16'd26;
	localparam logic [4:0]  GAP_MAX        = 5'd28;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DST_MAC    = 3'd0,
		REG_SRC_MAC    = 3'd1,
		REG_FRAME_SIZE = 3'd2,
		REG_GAP_MIN    = 3'd3,
		REG_IDLE_VALUE = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		KIND_PRE     = 3'd0,
		KIND_SFD     = 3'd1,
		KIND_DEST    = 3'd2,
		KIND_SRC     = 3'd3,
		KIND_LEN     = 3'd4,
		KIND_PAYLOAD = 3'd5,
		KIND_CRC     = 3'd6,
		KIND_IDLE    = 3'd7
	} kind_t;

	// header byte positions
	localparam logic [4:0] HDR_SFD     = 5'd7;
	localparam logic [4:0] HDR_DEST    = 5'd8;
	localparam logic [4:0] HDR_SRC     = 5'd14;
	localparam logic [4:0] HDR_LEN_HI  = 5'd20;
	localparam logic [4:0] HDR_LAST    = 5'd21;
	localparam logic [4:0] CRC_LAST    = 5'd3;

	// one classified payload byte passed from front to back
	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [31:0] crc;
	} entry_t;

	typedef struct packed {
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [15:0] frame_size;
		logic [4:0]  gap_min;
		logic [7:0]  idle_value;
	} cfg_t;

	function automatic logic [31:0] crc_update(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

	function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
		logic [7:0] r;
		case (k)
			3'd0: r = mac[47:40];
			3'd1: r = mac[39:32];
			3'd2: r = mac[31:24];
			3'd3: r = mac[23:16];
			3'd4: r = mac[15:8];
			3'd5: r = mac[7:0];
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// gap clamped to the maximum and rounded up to a multiple of four
	function automatic logic [4:0] gap_round(input logic [4:0] g);
		logic [5:0] s;
		s = {1'b0, (g > GAP_MAX) ? GAP_MAX : g} + 6'd3;
		return {s[4:2], 2'b00};
	endfunction

endpackage

`default_nettype wire

### rtl/core/efb_fifo.sv
// small queue between the classifying front and the expanding back
`default_nettype none

module efb_fifo
	import efb_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   wr_en,
	input  wire entry_t wr_data,
	output logic        full,
	input  wire logic   rd_en,
	output entry_t      rd_data,
	output logic        not_empty
);

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/efb_front.sv
// front end: takes payload bytes, tracks frame position and runs the crc
`default_nettype none

module efb_front
	import efb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  payload_byte,
	input  wire logic [15:0] frame_size,
	output entry_t           entry
);

	logic [15:0] seen_q;
	logic [31:0] crc_q;

	logic [15:0] count;
	logic [15:0] seen_nxt;
	logic [31:0] crc_nxt;
	logic        last;

	always_comb begin
		count    = (frame_size > FRAME_OVERHEAD) ? (frame_size - FRAME_OVERHEAD) : 16'd1;
		seen_nxt = seen_q + 16'd1;
		crc_nxt  = crc_update(crc_q, payload_byte);
		// wrap of the byte counter also ends the frame
		last     = (seen_nxt >= count) || (seen_nxt == '0);

		entry.data  = payload_byte;
		entry.first = (seen_q == '0);
		entry.last  = last;
		entry.crc   = ~crc_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			crc_q  <= CRC_SEED;
		end else if (accept) begin
			if (last) begin
				seen_q <= '0;
				crc_q  <= CRC_SEED;
			end else begin
				seen_q <= seen_nxt;
				crc_q  <= crc_nxt;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/efb_back.sv
// back end: expands each queued entry into header, payload, crc and gap bytes
`default_nettype none

module efb_back
	import efb_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire entry_t head,
	input  wire logic   head_valid,
	output logic        head_done,
	output logic        empty,
	input  wire logic   pop,
	output logic [7:0]  out_byte,
	output logic [2:0]  field_kind,
	output logic        run_last,
	output logic        frame_end
);

	typedef enum logic [4:0] {
		ST_NEW = 5'b00001,
		ST_HDR = 5'b00010,
		ST_PAY = 5'b00100,
		ST_CRC = 5'b01000,
		ST_GAP = 5'b10000
	} st_t;

	st_t        st_q;
	logic [4:0] idx_q;

	logic       ovalid_q;
	logic [7:0] obyte_q;
	kind_t      okind_q;
	logic       olast_q;
	logic       oend_q;

	st_t        cur_st;
	st_t        nxt_st;
	logic [4:0] nxt_idx;
	logic [4:0] gap_len;
	logic [4:0] off_dest;
	logic [4:0] off_src;
	logic       adv;
	logic       step;
	logic       done;
	logic [7:0] r_byte;
	kind_t      r_kind;
	logic       r_last;
	logic       r_end;

	assign adv       = !ovalid_q || pop;
	assign step      = adv && head_valid;
	assign head_done = step && done;

	assign empty      = !ovalid_q;
	assign out_byte   = obyte_q;
	assign field_kind = okind_q;
	assign run_last   = olast_q;
	assign frame_end  = oend_q;

	always_comb begin
		gap_len  = gap_round(cfg.gap_min);
		off_dest = idx_q - HDR_DEST;
		off_src  = idx_q - HDR_SRC;

		if (st_q == ST_NEW) begin
			cur_st = head.first ? ST_HDR : ST_PAY;
		end else begin
			cur_st = st_q;
		end

		r_byte  = head.data;
		r_kind  = KIND_PAYLOAD;
		r_last  = 1'b0;
		r_end   = 1'b0;
		done    = 1'b0;
		nxt_st  = cur_st;
		nxt_idx = idx_q + 5'd1;

		case (cur_st)
			ST_HDR: begin
				case (idx_q) inside
					5'd0: begin
						r_byte = BYTE_START;
						r_kind = KIND_PRE;
					end
					[5'd1:5'd6]: begin
						r_byte = BYTE_PRE;
						r_kind = KIND_PRE;
					end
					HDR_SFD: begin
						r_byte = BYTE_SFD;
						r_kind = KIND_SFD;
					end
					[5'd8:5'd13]: begin
						r_byte = mac_byte(cfg.dst_mac, off_dest[2:0]);
						r_kind = KIND_DEST;
					end
					[5'd14:5'd19]: begin
						r_byte = mac_byte(cfg.src_mac, off_src[2:0]);
						r_kind = KIND_SRC;
					end
					HDR_LEN_HI: begin
						r_byte = cfg.frame_size[15:8];
						r_kind = KIND_LEN;
					end
					default: begin
						r_byte = cfg.frame_size[7:0];
						r_kind = KIND_LEN;
					end
				endcase
				if (idx_q == HDR_LAST) begin
					nxt_st  = ST_PAY;
					nxt_idx = '0;
				end
			end
			ST_PAY: begin
				if (head.last) begin
					nxt_st  = ST_CRC;
					nxt_idx = '0;
				end else begin
					r_last = 1'b1;
					done   = 1'b1;
				end
			end
			ST_CRC: begin
				r_kind = KIND_CRC;
				case (idx_q[1:0])
					2'd0:    r_byte = head.crc[31:24];
					2'd1:    r_byte = head.crc[23:16];
					2'd2:    r_byte = head.crc[15:8];
					default: r_byte = head.crc[7:0];
				endcase
				if (idx_q == CRC_LAST) begin
					r_end   = 1'b1;
					nxt_st  = ST_GAP;
					nxt_idx = '0;
					if (gap_len == '0) begin
						r_last = 1'b1;
						done   = 1'b1;
					end
				end
			end
			ST_GAP: begin
				r_byte = cfg.idle_value;
				r_kind = KIND_IDLE;
				if (idx_q == gap_len - 5'd1) begin
					r_last = 1'b1;
					done   = 1'b1;
				end
			end
			default: begin
				nxt_st = ST_NEW;
			end
		endcase

		if (done) begin
			nxt_st  = ST_NEW;
			nxt_idx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_NEW;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (step) begin
				st_q  <= nxt_st;
				idx_q <= nxt_idx;
			end
			if (adv) begin
				ovalid_q <= head_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			obyte_q <= r_byte;
			okind_q <= r_kind;
			olast_q <= r_last;
			oend_q  <= r_end;
		end
	end

endmodule

`default_nettype wire

### rtl/core/ethernet_frame_builder.sv
// top level of the ethernet frame builder: config registers, front, queue and back
// throughput: one output byte per cycle while popped with data queued; a payload
// byte makes 1 byte mid-frame, 23 at frame start, 5 + rounded gap (<=28) at end
// input is taken every cycle while the 4-entry queue has room
// reset: async active low; clears frame position, crc, queue and output valid,
// and loads config defaults (size 64, gap 12, idle byte 7, macs zero)
`default_nettype none

module ethernet_frame_builder
	import efb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// payload input, queue style
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [7:0]            payload_byte,
	// framed output, queue style
	output logic                       empty,
	input  wire logic                  pop,
	output logic [7:0]                 out_byte,
	output logic [2:0]                 field_kind,
	output logic                       run_last,
	output logic                       frame_end,
	// config write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg_q;
	entry_t front_entry;
	entry_t head;
	logic   head_valid;
	logic   head_done;
	logic   in_xfer;

	// config registers always take a write; cfg_ready is tied high
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dst_mac    <= '0;
			cfg_q.src_mac    <= '0;
			cfg_q.frame_size <= 16'd64;
			cfg_q.gap_min    <= 5'd12;
			cfg_q.idle_value <= 8'd7;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DST_MAC:    cfg_q.dst_mac    <= cfg_data;
				REG_SRC_MAC:    cfg_q.src_mac    <= cfg_data;
				REG_FRAME_SIZE: cfg_q.frame_size <= cfg_data[15:0];
				REG_GAP_MIN:    cfg_q.gap_min    <= cfg_data[4:0];
				REG_IDLE_VALUE: cfg_q.idle_value <= cfg_data[7:0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	// input transfer goes straight into the queue
	assign in_xfer = push && !full;

	// front: frame position and crc per payload byte
	efb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_xfer),
		.payload_byte (payload_byte),
		.frame_size   (cfg_q.frame_size),
		.entry        (front_entry)
	);

	// decoupling queue: front keeps taking bytes while back sends a header or gap
	efb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (in_xfer),
		.wr_data   (front_entry),
		.full      (full),
		.rd_en     (head_done),
		.rd_data   (head),
		.not_empty (head_valid)
	);

	// back: one output byte per cycle into the output register while popped
	efb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.head_done  (head_done),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.field_kind (field_kind),
		.run_last   (run_last),
		.frame_end  (frame_end)
	);

endmodule

`default_nettype wire

### dv/ethernet_frame_builder_test.sv
// testbench for the ethernet frame builder: directed table, then random frames checked byte by byte
`timescale 1ns / 100ps

module ethernet_frame_builder_test;
	import efb_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 30;
	localparam int STALL_LIMIT = 2000;       // longest quiet stretch is the receiver hold-off
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_PHASES = 7;
	localparam int MAX_LINES = 200;

	// index that maps to no register; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	// known crc values of one-byte frames
	localparam logic [31:0] CRC_OF_FF = 32'hFF000000;
	localparam logic [31:0] CRC_OF_00 = 32'hD202EF8D;

	typedef enum logic [1:0] {
		ROW_REG  = 2'd0,
		ROW_BYTE = 2'd1
	} row_op_t;

	typedef struct packed {
		row_op_t                op;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic                   crc_known;
		logic [31:0]            crc;
	} plan_row_t;

	// one byte of the framed stream as it should leave the block
	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       run_last;
		logic       frame_end;
	} frame_byte_t;

	// directed part: register writes and payload bytes in order; crc typed in where obvious
	localparam int PLAN_ROWS = 34;
	localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
		// first byte after reset: header built from reset values, length 0x0040
		'{ROW_BYTE, REG_NONE,       48'h00,              1'b0, 32'h0},
		// size cut to the bytes already taken: next byte closes the frame
		'{ROW_REG,  REG_FRAME_SIZE, 48'd27,              1'b0, 32'h0},
		'{ROW_BYTE, REG_NONE,       48'hFF,              1'b0, 32'h0},
		'{ROW_REG,  REG_DST_MAC,    48'hFFFF_FFFF_FFFF,  1'b0, 32'h0},
		'{ROW_REG,  REG_SRC_MAC,    48'h0,               1'b0, 32'h0},
		'{ROW_REG,  REG_GAP_MIN,    48'd0,               1'b0, 32'h0},
		'{ROW_REG,  REG_IDLE_VALUE, 48'hFF,              1'b0, 32'h0},
		// one-byte frame with no gap at all
		'{ROW_BYTE, REG_NONE,       48'hFF,              1'b1, CRC_OF_FF},
		// size below the header: every byte is a frame of its own
		'{ROW_REG,  REG_FRAME_SIZE, 48'd0,               1'b0, 32'h0},
		// gap above the maximum clamps to 28
		'{ROW_REG,  REG_GAP_MIN,    48'd31,              1'b0, 32'h0},
		'{ROW_REG,  REG_IDLE_VALUE, 48'h00,              1'b0, 32'h0},
		'{ROW_REG,  REG_NONE,       48'hA5A5_0000_0001,  1'b0, 32'h0},
		'{ROW_BYTE, REG_NONE,       48'h00,              1'b1, CRC_OF_00},
		'{ROW_REG,  REG_DST_MAC,    48'h0,               1'b0, 32'h0},
		'{ROW_REG,  REG_SRC_MAC,    48'hFFFF_FFFF_FFFF,  1'b0, 32'h0},
		'{ROW_REG,  REG_FRAME_SIZE, 48'd26,              1'b0, 32'h0},
		// gap of one rounds up to four
		'{ROW_REG,  REG_GAP_MIN,    48'd1,               1'b0, 32'h0},
		'{ROW_BYTE, REG_NONE,       48'h80,              1'b0, 32'h0},
		'{ROW_BYTE, REG_NONE,       48'h01,              1'b0, 32'h0},
		// largest size: length field 0xFFFF, then cut down mid-frame
		'{ROW_REG,  REG_FRAME_SIZE, 48'd65535,           1'b0, 32'h0},
		'{ROW_REG,  REG_GAP_MIN,    48'd28,              1'b0, 32'h0},
		'{ROW_BYTE, REG_NONE,       48'h5A,              1'b0, 32'h0},
		'{ROW_BYTE, REG_NONE,       48'hA5,              1'b0, 32'h0},
		'{ROW_BYTE, REG_NONE,       48'h0F,              1'b0, 32'h0},
		'{ROW_REG,  REG_FRAME_SIZE, 48'd28,              1'b0, 32'h0},
		'{ROW_BYTE, REG_NONE,       48'hF0,              1'b0, 32'h0},
		// a plain three-byte frame
		'{ROW_REG,  REG_FRAME_SIZE, 48'd29,              1'b0, 32'h0},
		'{ROW_REG,  REG_GAP_MIN,    48'd3,               1'b0, 32'h0},
		'{ROW_REG,  REG_IDLE_VALUE, 48'h55,              1'b0, 32'h0},
		'{ROW_REG,  REG_DST_MAC,    48'h0123_4567_89AB,  1'b0, 32'h0},
		'{ROW_REG,  REG_SRC_MAC,    48'hFEDC_BA98_7654,  1'b0, 32'h0},
		'{ROW_BYTE, REG_NONE,       48'h12,              1'b0, 32'h0},
		'{ROW_BYTE, REG_NONE,       48'h34,              1'b0, 32'h0},
		'{ROW_BYTE, REG_NONE,       48'h56,              1'b0, 32'h0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [7:0]            payload_byte = 8'h00;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [7:0]            out_byte;
	logic [2:0]            field_kind;
	logic                  run_last;
	logic                  frame_end;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of the registers and the frame state
	cfg_t        shadow;
	logic [15:0] pay_count;
	logic [31:0] crc_run;

	// bytes the block still owes, oldest first
	frame_byte_t frame_bytes_q[$];
	frame_byte_t pend;
	bit          pend_valid = 1'b0;

	int mismatches = 0;
	int hold_left = 0;       // receiver hold-off, counted down by the receiver
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;

	ethernet_frame_builder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.payload_byte (payload_byte),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.field_kind   (field_kind),
		.run_last     (run_last),
		.frame_end    (frame_end),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		if (mismatches < MAX_LINES)
			$display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	function automatic logic [47:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[47:0];
	endfunction

	// reflected crc-32, one data bit at a time
	function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] r;
		r = c;
		for (int k = 0; k < 8; k++) begin
			if (r[0] ^ d[k])
				r = {1'b0, r[31:1]} ^ CRC_POLY;
			else
				r = {1'b0, r[31:1]};
		end
		return r;
	endfunction

	// the last queued byte of an item is held back so run_last and frame_end can be set on it
	task automatic owe_byte(input logic [7:0] d, input kind_t k);
		if (pend_valid)
			frame_bytes_q.push_back(pend);
		pend = '{data: d, kind: k, run_last: 1'b0, frame_end: 1'b0};
		pend_valid = 1'b1;
	endtask

	// everything one accepted payload byte makes the block send
	task automatic build_frame_bytes(input logic [7:0] b, input logic crc_known,
			input logic [31:0] crc_given);
		logic [15:0] needed;
		logic [31:0] crc_out;
		logic [4:0]  g;
		int          idle_n;
		needed = (shadow.frame_size > FRAME_OVERHEAD) ? shadow.frame_size - FRAME_OVERHEAD : 16'd1;
		if (pay_count == 16'd0) begin
			owe_byte(BYTE_START, KIND_PRE);
			for (int i = 0; i < 6; i++)
				owe_byte(BYTE_PRE, KIND_PRE);
			owe_byte(BYTE_SFD, KIND_SFD);
			for (int i = 5; i >= 0; i--)
				owe_byte(shadow.dst_mac[8*i +: 8], KIND_DEST);
			for (int i = 5; i >= 0; i--)
				owe_byte(shadow.src_mac[8*i +: 8], KIND_SRC);
			owe_byte(shadow.frame_size[15:8], KIND_LEN);
			owe_byte(shadow.frame_size[7:0], KIND_LEN);
		end
		owe_byte(b, KIND_PAYLOAD);
		crc_run = crc_next(crc_run, b);
		pay_count = pay_count + 16'd1;
		// a lowered size ends the frame as soon as the count reaches or passes it
		if (pay_count >= needed || pay_count == 16'd0) begin
			crc_out = crc_known ? crc_given : ~crc_run;
			for (int i = 3; i >= 0; i--)
				owe_byte(crc_out[8*i +: 8], KIND_CRC);
			pend.frame_end = 1'b1;
			g = (shadow.gap_min > GAP_MAX) ? GAP_MAX : shadow.gap_min;
			idle_n = (int'(g) + 3) / 4 * 4;
			for (int i = 0; i < idle_n; i++)
				owe_byte(shadow.idle_value, KIND_IDLE);
			pay_count = 16'd0;
			crc_run = CRC_SEED;
		end
		pend.run_last = 1'b1;
		frame_bytes_q.push_back(pend);
		pend_valid = 1'b0;
	endtask

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_DST_MAC:    shadow.dst_mac = d[47:0];
			REG_SRC_MAC:    shadow.src_mac = d[47:0];
			REG_FRAME_SIZE: shadow.frame_size = d[15:0];
			REG_GAP_MIN:    shadow.gap_min = d[4:0];
			REG_IDLE_VALUE: shadow.idle_value = d[7:0];
			default: ;
		endcase
	endtask

	// block is idle once every owed byte has left, plus a few cycles of margin
	task automatic wait_idle();
		while (frame_bytes_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		push <= 1'b0;
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, d);
		cfg_valid <= 1'b0;
	endtask

	// push stays high from one transfer to the next unless a gap is taken
	task automatic send_byte(input logic [7:0] b, input logic crc_known, input logic [31:0] crc_given);
		while (tx_gaps && $urandom_range(99) < 11) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		payload_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		build_frame_bytes(b, crc_known, crc_given);
	endtask

	task automatic check_result();
		frame_byte_t want;
		if (frame_bytes_q.size() == 0) begin
			report("unexpected result", {24'd0, out_byte}, 32'd0);
			return;
		end
		want = frame_bytes_q.pop_front();
		if (out_byte !== want.data)
			report("out_byte", {24'd0, out_byte}, {24'd0, want.data});
		if (field_kind !== want.kind)
			report("field_kind", {29'd0, field_kind}, {29'd0, want.kind});
		if (run_last !== want.run_last)
			report("run_last", {31'd0, run_last}, {31'd0, want.run_last});
		if (frame_end !== want.frame_end)
			report("frame_end", {31'd0, frame_end}, {31'd0, want.frame_end});
	endtask

	// receiver: checks each result transfer, pops with random gaps or holds off on request
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && pop && empty === 1'b0)
				check_result();
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= arst_n && !(rx_gaps && $urandom_range(99) < 11);
			end
		end
	end

	// watchdog: ends the run after too many cycles with no transfer on any port
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// stimulus: reset, directed table, random phases, drain
	initial begin : stimulus
		logic [47:0] junk;
		logic [15:0] fs;
		int          items;
		shadow = '{dst_mac: 48'd0, src_mac: 48'd0, frame_size: 16'd64, gap_min: 5'd12,
			idle_value: 8'd7};
		pay_count = 16'd0;
		crc_run = CRC_SEED;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < PLAN_ROWS; r++) begin
			if (PLAN[r].op == ROW_REG)
				write_reg(PLAN[r].idx, PLAN[r].data);
			else
				send_byte(PLAN[r].data[7:0], PLAN[r].crc_known, PLAN[r].crc);
		end

		// random phases: every register rewritten while idle, then a run of payload bytes
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(3))
				0: write_reg(REG_DST_MAC, 48'd0);
				1: write_reg(REG_DST_MAC, 48'hFFFF_FFFF_FFFF);
				default: write_reg(REG_DST_MAC, rand48());
			endcase
			case ($urandom_range(3))
				0: write_reg(REG_SRC_MAC, 48'd0);
				1: write_reg(REG_SRC_MAC, 48'hFFFF_FFFF_FFFF);
				default: write_reg(REG_SRC_MAC, rand48());
			endcase
			// mostly short frames; one phase at the largest size so the next one cuts it
			if (p == 3)
				fs = 16'hFFFF;
			else if ($urandom_range(4) == 0)
				fs = 16'($urandom_range(26));
			else
				fs = 16'($urandom_range(44, 27));
			// unused upper data bits carry noise on the narrow registers
			junk = rand48();
			write_reg(REG_FRAME_SIZE, {junk[47:16], fs});
			junk = rand48();
			write_reg(REG_GAP_MIN, {junk[47:5], 5'($urandom_range(31))});
			junk = rand48();
			write_reg(REG_IDLE_VALUE, {junk[47:8], 8'($urandom_range(255))});

			// one phase with no gaps on either side
			tx_gaps = (p != 5);
			rx_gaps = (p != 5);
			// receiver holds off so the queue fills and full rises
			if (p == 2)
				hold_left = HOLD_CYCLES;

			items = $urandom_range(18, 10);
			for (int i = 0; i < items; i++)
				send_byte(8'($urandom_range(255)), 1'b0, 32'd0);
		end

		push <= 1'b0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		while (frame_bytes_q.size() != 0)
			@(posedge clk);
		// late extra results show up as unexpected
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### files.f
rtl/core/efb_pkg.sv
rtl/core/efb_fifo.sv
rtl/core/efb_front.sv
rtl/core/efb_back.sv
rtl/core/ethernet_frame_builder.sv
dv/ethernet_frame_builder_test.sv
